// ----- hdl/hmw_pkg.sv -----
// ----------------------------------------------------------------------------
// hmw_pkg
// Shared constants, types and sequencer states of the half-maximum width
// estimator.
// ----------------------------------------------------------------------------
package hmw_pkg;

    // Profile length and fixed-point format
    localparam int MAX_POINTS    = 128;
    localparam int FRAC_BITS     = 8;

    // Field widths
    localparam int SAMPLE_W      = 16;
    localparam int PEAK_W        = 17;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;

    // Sample counter holds 0..MAX_POINTS, edge positions 0..MAX_POINTS-1
    localparam int POS_W         = $clog2(MAX_POINTS + 1);
    localparam int EPOS_W        = $clog2(MAX_POINTS);

    // Divider: |numerator| << (FRAC_BITS-1) over |sample difference|
    localparam int NUM_W         = PEAK_W;
    localparam int DEN_W         = SAMPLE_W;
    localparam int QUO_W         = NUM_W + FRAC_BITS - 1;
    localparam int CNT_W         = $clog2(QUO_W + 1);

    // Signed edge position and width intermediates
    localparam int EDGE_W        = QUO_W + 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_WIDTH = 2'd2;

    // Register reset values (Q8.8)
    localparam logic [CFG_W-1:0] MIN_WIDTH_RST      = CFG_W'(5  << FRAC_BITS);
    localparam logic [CFG_W-1:0] MAX_WIDTH_RST      = CFG_W'(30 << FRAC_BITS);
    localparam logic [CFG_W-1:0] FALLBACK_WIDTH_RST = CFG_W'(10 << FRAC_BITS);

    // Edge positions used when no crossing is found
    localparam logic signed [EDGE_W-1:0] LEFT_DEFAULT  = EDGE_W'(20 << FRAC_BITS);
    localparam logic signed [EDGE_W-1:0] RIGHT_DEFAULT = EDGE_W'(40 << FRAC_BITS);

    // Output beat layout
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 24;
    localparam int OUT_LEFT_BIT  = CFG_W;
    localparam int OUT_RIGHT_BIT = CFG_W + 1;
    localparam int OUT_FB_BIT    = CFG_W + 2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_TRACK,
        ST_START_L,
        ST_WAIT_L,
        ST_START_R,
        ST_WAIT_R,
        ST_WIDTH,
        ST_OUT
    } t_state;

    // Edge tracking state seen by the sequencer
    typedef struct packed {
        logic [PEAK_W-1:0]   thr;
        logic                left_hit;
        logic [EPOS_W-1:0]   left_pos;
        logic [SAMPLE_W-1:0] left_a;
        logic [SAMPLE_W-1:0] left_b;
        logic                right_hit;
        logic [EPOS_W-1:0]   right_pos;
        logic [SAMPLE_W-1:0] right_a;
        logic [SAMPLE_W-1:0] right_b;
    } t_track;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- hdl/half_max_width_estimator.sv -----
// ----------------------------------------------------------------------------
// half_max_width_estimator
// Full width at half maximum of one star profile, with linear interpolation
// of both half-maximum crossings.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one profile sample per beat; tdata holds the
//   sample in bits 15:0 and the peak intensity in bits 32:16 (peak is taken
//   from the first beat of a profile only); tlast marks the final sample.
//   Output stream m_axis carries one result beat per profile.
//   Samples are taken one per cycle. After the tlast beat the block drops
//   tready while one shared restoring divider interpolates the left and then
//   the right edge, one quotient bit per cycle; the width and the result beat
//   follow. The result sits in an output register: a stalled receiver does
//   not stop the next profile from loading; only a second result waiting on
//   the first holds the sequencer (and tready) until the first beat is taken.
//   Reset (synchronous, active low) clears the profile state, drops m_axis
//   tvalid and restores the width registers to 5.0, 30.0 and 10.0 (Q8.8).
//   Configuration writes take effect at once. The user must make them only
//   while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module half_max_width_estimator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [hmw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hmw_pkg::CFG_W-1:0]       i_cfg_data,
    // Sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] sample, [32:16] peak_intensity, [39:33] zero
    input  logic [hmw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] width, [16] left_found, [17] right_found, [18] used_fallback,
    // [23:19] zero
    output logic [hmw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    hmw_pkg::t_state r_state, n_state;

    logic [hmw_pkg::CFG_W-1:0] r_min_width;
    logic [hmw_pkg::CFG_W-1:0] r_max_width;
    logic [hmw_pkg::CFG_W-1:0] r_fallback;

    hmw_pkg::t_track  trk;
    hmw_pkg::t_div_req div_req;
    hmw_pkg::t_div_rsp div_rsp;

    logic sample_beat;
    logic trk_clear;
    logic out_load;
    logic out_free;
    logic div_start;

    // Operand selection
    logic                              sel_right;
    logic [hmw_pkg::SAMPLE_W-1:0]      op_a;
    logic [hmw_pkg::SAMPLE_W-1:0]      op_b;
    logic signed [hmw_pkg::NUM_W+1:0]  num;
    logic signed [hmw_pkg::DEN_W+1:0]  den;
    logic [hmw_pkg::NUM_W-1:0]         num_mag;
    logic [hmw_pkg::DEN_W-1:0]         den_mag;

    logic r_neg,  n_neg;
    logic r_zero, n_zero;

    // Edge capture
    logic                              cap_hit;
    logic [hmw_pkg::EPOS_W-1:0]        cap_pos;
    logic signed [hmw_pkg::EDGE_W-1:0] frac;
    logic signed [hmw_pkg::EDGE_W-1:0] edge_val;

    logic signed [hmw_pkg::EDGE_W-1:0] r_left,  n_left;
    logic signed [hmw_pkg::EDGE_W-1:0] r_right, n_right;
    logic signed [hmw_pkg::EDGE_W-1:0] r_width, n_width;

    // Range test
    logic signed [hmw_pkg::EDGE_W-1:0] min_s;
    logic signed [hmw_pkg::EDGE_W-1:0] max_s;
    logic                              use_fb;
    logic [hmw_pkg::CFG_W-1:0]         res_width;

    logic                              r_out_valid, n_out_valid;
    logic [hmw_pkg::OUT_DATA_W-1:0]    r_out_data,  n_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= hmw_pkg::MIN_WIDTH_RST;
            r_max_width <= hmw_pkg::MAX_WIDTH_RST;
            r_fallback  <= hmw_pkg::FALLBACK_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hmw_pkg::REG_MIN_WIDTH:      r_min_width <= i_cfg_data;
                hmw_pkg::REG_MAX_WIDTH:      r_max_width <= i_cfg_data;
                hmw_pkg::REG_FALLBACK_WIDTH: r_fallback  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge search
    hmw_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (sample_beat),
        .i_sample (s_axis_tdata[hmw_pkg::SAMPLE_W-1:0]),
        .i_peak   (s_axis_tdata[hmw_pkg::SAMPLE_W +: hmw_pkg::PEAK_W]),
        .i_clear  (trk_clear),
        .o_track  (trk)
    );

    // Shared divider
    hmw_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hmw_pkg::ST_TRACK: begin
                if (s_axis_tvalid && s_axis_tlast) begin
                    n_state = hmw_pkg::ST_START_L;
                end
            end
            hmw_pkg::ST_START_L: n_state = hmw_pkg::ST_WAIT_L;
            hmw_pkg::ST_WAIT_L: begin
                if (div_rsp.done) begin
                    n_state = hmw_pkg::ST_START_R;
                end
            end
            hmw_pkg::ST_START_R: n_state = hmw_pkg::ST_WAIT_R;
            hmw_pkg::ST_WAIT_R: begin
                if (div_rsp.done) begin
                    n_state = hmw_pkg::ST_WIDTH;
                end
            end
            hmw_pkg::ST_WIDTH: n_state = hmw_pkg::ST_OUT;
            hmw_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = hmw_pkg::ST_TRACK;
                end
            end
            default: n_state = hmw_pkg::ST_TRACK;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        trk_clear     = 1'b0;
        out_load      = 1'b0;
        sel_right     = 1'b0;
        case (r_state)
            hmw_pkg::ST_TRACK:   s_axis_tready = 1'b1;
            hmw_pkg::ST_START_L: div_start = 1'b1;
            hmw_pkg::ST_START_R: begin
                div_start = 1'b1;
                sel_right = 1'b1;
            end
            hmw_pkg::ST_OUT: begin
                out_load  = out_free;
                trk_clear = out_free;
            end
            default: ;
        endcase
    end

    assign sample_beat = s_axis_tvalid && s_axis_tready;

    // Form numerator and denominator of the crossing fraction
    always_comb begin
        op_a = sel_right ? trk.right_a : trk.left_a;
        op_b = sel_right ? trk.right_b : trk.left_b;
        if (sel_right) begin
            num = $signed({2'b00, op_a, 1'b0}) - $signed({2'b00, trk.thr});
            den = $signed({2'b00, op_a}) - $signed({2'b00, op_b});
        end else begin
            num = $signed({2'b00, trk.thr}) - $signed({2'b00, op_a, 1'b0});
            den = $signed({2'b00, op_b}) - $signed({2'b00, op_a});
        end
        num_mag = num[hmw_pkg::NUM_W+1] ? hmw_pkg::NUM_W'(-num) : num[hmw_pkg::NUM_W-1:0];
        den_mag = den[hmw_pkg::DEN_W+1] ? hmw_pkg::DEN_W'(-den) : den[hmw_pkg::DEN_W-1:0];
    end

    // Numerator carries FRAC_BITS-1 extra bits since the numerator is doubled
    assign div_req = {div_start, num_mag, {(hmw_pkg::FRAC_BITS-1){1'b0}}, den_mag};

    // Hold the quotient sign and the zero-denominator case
    always_comb begin
        n_neg  = r_neg;
        n_zero = r_zero;
        if (div_start) begin
            n_neg  = num[hmw_pkg::NUM_W+1] ^ den[hmw_pkg::DEN_W+1];
            n_zero = (den_mag == '0);
        end
    end

    // Turn the quotient into an edge position
    always_comb begin
        cap_hit = (r_state == hmw_pkg::ST_WAIT_R) ? trk.right_hit : trk.left_hit;
        cap_pos = (r_state == hmw_pkg::ST_WAIT_R) ? trk.right_pos : trk.left_pos;
        if (r_zero) begin
            frac = '0;
        end else if (r_neg) begin
            frac = -$signed(hmw_pkg::EDGE_W'(div_rsp.quotient));
        end else begin
            frac = $signed(hmw_pkg::EDGE_W'(div_rsp.quotient));
        end
        edge_val = $signed(hmw_pkg::EDGE_W'(cap_pos) << hmw_pkg::FRAC_BITS) + frac;
    end

    // Capture edges and the width
    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_width = r_width;
        if (r_state == hmw_pkg::ST_WAIT_L && div_rsp.done) begin
            n_left = cap_hit ? edge_val : hmw_pkg::LEFT_DEFAULT;
        end
        if (r_state == hmw_pkg::ST_WAIT_R && div_rsp.done) begin
            n_right = cap_hit ? edge_val : hmw_pkg::RIGHT_DEFAULT;
        end
        if (r_state == hmw_pkg::ST_WIDTH) begin
            n_width = r_right - r_left;
        end
    end

    // Range test against the width limits
    assign min_s     = $signed(hmw_pkg::EDGE_W'(r_min_width));
    assign max_s     = $signed(hmw_pkg::EDGE_W'(r_max_width));
    assign use_fb    = (r_width < min_s) || (r_width > max_s);
    assign res_width = use_fb ? r_fallback : r_width[hmw_pkg::CFG_W-1:0];

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = hmw_pkg::OUT_DATA_W'({use_fb, trk.right_hit, trk.left_hit,
                                                 res_width});
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmw_pkg::ST_TRACK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_left     <= n_left;
        r_right    <= n_right;
        r_width    <= n_width;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Block no beat may follow a profile's last sample directly
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("sample accepted right after end of profile");

    // A new result appears only out of the final sequencer step
    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> ($past(r_state) == hmw_pkg::ST_OUT))
        else $error("result beat without finished sequence");

    // Divider completes only while an edge is awaited
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == hmw_pkg::ST_WAIT_L || r_state == hmw_pkg::ST_WAIT_R))
        else $error("divider done outside a wait step");

    // A replaced width carries the fallback value
    a_fallback_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[hmw_pkg::OUT_FB_BIT])
            |-> (m_axis_tdata[hmw_pkg::CFG_W-1:0] == r_fallback))
        else $error("fallback flag set without fallback width");

endmodule

// ----- hdl/hmw_tracker.sv -----
// ----------------------------------------------------------------------------
// hmw_tracker
// Per-sample edge search: latches the peak, finds the first rising and the
// last falling half-maximum crossing and keeps the sample pairs around them.
// ----------------------------------------------------------------------------
module hmw_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_beat,
    input  logic [hmw_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [hmw_pkg::PEAK_W-1:0]    i_peak,
    input  logic                          i_clear,
    output hmw_pkg::t_track               o_track
);

    logic [hmw_pkg::POS_W-1:0]    r_pos,  n_pos;
    logic [hmw_pkg::SAMPLE_W-1:0] r_prev, n_prev;
    hmw_pkg::t_track              r_trk,  n_trk;

    logic [hmw_pkg::PEAK_W-1:0]   thr;
    logic [hmw_pkg::PEAK_W-1:0]   y2;
    logic [hmw_pkg::PEAK_W-1:0]   prev2;

    // Threshold comparisons are made as 2*sample against the peak
    assign thr   = (r_pos == '0) ? i_peak : r_trk.thr;
    assign y2    = {i_sample, 1'b0};
    assign prev2 = {r_prev, 1'b0};

    // Advance the search on each sample beat
    always_comb begin
        n_pos  = r_pos;
        n_prev = r_prev;
        n_trk  = r_trk;
        if (i_clear) begin
            n_pos  = '0;
            n_prev = '0;
            n_trk  = '0;
        end else if (i_beat) begin
            n_trk.thr = thr;
            if (r_pos < hmw_pkg::POS_W'(hmw_pkg::MAX_POINTS)) begin
                if (r_pos != '0) begin
                    if (!r_trk.left_hit && (y2 >= thr)) begin
                        n_trk.left_hit = 1'b1;
                        n_trk.left_pos = r_pos[hmw_pkg::EPOS_W-1:0];
                        n_trk.left_a   = r_prev;
                        n_trk.left_b   = i_sample;
                    end
                    if (prev2 > thr) begin
                        n_trk.right_hit = 1'b1;
                        n_trk.right_pos = r_pos[hmw_pkg::EPOS_W-1:0];
                        n_trk.right_a   = r_prev;
                        n_trk.right_b   = i_sample;
                    end
                end
                n_prev = i_sample;
                n_pos  = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= '0;
            r_trk  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_prev <= n_prev;
            r_trk  <= n_trk;
        end
    end

    assign o_track = r_trk;

endmodule

// ----- hdl/hmw_divider.sv -----
// ----------------------------------------------------------------------------
// hmw_divider
// Unsigned restoring divider, one quotient bit per cycle, shared by the left
// and right edge interpolation.
// ----------------------------------------------------------------------------
module hmw_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmw_pkg::t_div_req i_req,
    output hmw_pkg::t_div_rsp o_rsp
);

    logic                         r_busy, n_busy;
    logic [hmw_pkg::CNT_W-1:0]    r_cnt,  n_cnt;
    logic [hmw_pkg::DEN_W-1:0]    r_rem,  n_rem;
    logic [hmw_pkg::QUO_W-1:0]    r_quo,  n_quo;
    logic [hmw_pkg::DEN_W-1:0]    r_div,  n_div;

    logic [hmw_pkg::DEN_W:0]      trial;

    // Bring down the next dividend bit
    assign trial = {r_rem, r_quo[hmw_pkg::QUO_W-1]};

    // Load on start, then one trial subtraction per cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = hmw_pkg::CNT_W'(hmw_pkg::QUO_W);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (trial >= {1'b0, r_div}) begin
                    n_rem = hmw_pkg::DEN_W'(trial - {1'b0, r_div});
                    n_quo = {r_quo[hmw_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[hmw_pkg::DEN_W-1:0];
                    n_quo = {r_quo[hmw_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    // Response: done flag above the quotient
    assign o_rsp = {r_busy && (r_cnt == '0), r_quo};

endmodule
